[src/sal_pkg.sv]
// Shared types and codes for the shift array list.
package sal_pkg;

	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_SEARCH = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_MISS  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_SCAN,
		S_DONE
	} state_t;

	// Cells examined per scan cycle, at most.
	localparam int GRP_MAX = 8;

	// Broadcast control from the sequencer to every cell.
	typedef struct packed {
		logic        shift;   // insert at front: every cell takes its left neighbour
		logic        app;     // append: the cell at the fill position takes the value
		logic        load;    // load match and tail taps from the held entries
		logic        scan;    // move match and tail taps one group towards cell 0
		logic [31:0] value;
	} cell_ctl_t;

endpackage

[src/sal_cell.sv]
// One list position: entry register plus match and tail taps for the group scan.
module sal_cell #(
	parameter int IDX = 0,
	parameter int FW  = 5
) (
	input  logic                clk,
	input  sal_pkg::cell_ctl_t  ctl,
	input  logic [FW-1:0]       fill,
	input  logic [31:0]         left_entry,
	input  logic                up_match,
	input  logic [31:0]         up_tap,
	output logic [31:0]         entry,
	output logic                match,
	output logic [31:0]         tap
);

	logic [31:0] entry_q;
	logic        match_q;
	logic [31:0] tap_q;
	logic        held;
	logic        is_tail;

	assign held    = FW'(IDX) < fill;
	assign is_tail = fill == FW'(IDX + 1);

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			entry_q <= left_entry;
		end else if (ctl.app && fill == FW'(IDX)) begin
			entry_q <= ctl.value;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			match_q <= held && (entry_q == ctl.value);
			tap_q   <= is_tail ? entry_q : 32'd0;
		end else if (ctl.scan) begin
			match_q <= up_match;
			tap_q   <= up_tap;
		end
	end

	assign entry = entry_q;
	assign match = match_q;
	assign tap   = tap_q;

endmodule

[src/shift_array_list.sv]
// Shift array list: one item accepted, then a load step, a scan over NGRP = ceil(CAPACITY/8)
// groups of cells and a result step that waits until the output register can take the result.
// No new item is taken until the result of the last one has gone to the output register.
// The output register lets the next item be taken while a result waits.
// arst_n clears the entry count, sequencer and output valid; entries hold no reset value.
module shift_array_list #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic signed [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        found,
	output logic [3:0]  found_index,
	output logic signed [31:0] first_value,
	output logic signed [31:0] last_value,
	output logic [4:0]  count,
	output logic        is_empty
);

	localparam int FW   = $clog2(CAPACITY + 1);
	localparam int GRP  = (CAPACITY < sal_pkg::GRP_MAX) ? CAPACITY : sal_pkg::GRP_MAX;
	localparam int NGRP = (CAPACITY + GRP - 1) / GRP;
	localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int GIW  = $clog2(GRP);
	localparam int PW   = GW + GIW;

	sal_pkg::state_t    state_q, state_d;
	sal_pkg::cell_ctl_t ctl;
	sal_pkg::act_t      act_q;
	sal_pkg::status_t   status_q;

	logic [FW-1:0] fill_q;
	logic [31:0]   value_q;
	logic [GW-1:0] grp_q;
	logic          found_q;
	logic [3:0]    idx_q;
	logic [31:0]   last_q;
	logic          acc;
	logic          full;
	logic          out_load;

	logic [31:0] entry_w [CAPACITY];
	logic        match_w [CAPACITY];
	logic [31:0] tap_w   [CAPACITY];

	logic          grp_hit;
	logic [GIW-1:0] grp_k;
	logic [31:0]   grp_tap;
	logic [PW-1:0] pos;

	logic                out_valid_q;
	sal_pkg::status_t    out_status_q;
	logic                out_found_q;
	logic [3:0]          out_idx_q;
	logic [31:0]         out_first_q;
	logic [31:0]         out_last_q;
	logic [4:0]          out_count_q;
	logic                out_empty_q;

	assign in_ready = state_q == sal_pkg::S_IDLE;
	assign acc      = in_valid && in_ready;
	assign full     = fill_q == FW'(CAPACITY);
	assign out_load = (state_q == sal_pkg::S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		ctl.shift = acc && (action == sal_pkg::ACT_INSERT) && !full;
		ctl.app   = acc && (action == sal_pkg::ACT_APPEND) && !full;
		ctl.load  = state_q == sal_pkg::S_LOAD;
		ctl.scan  = state_q == sal_pkg::S_SCAN;
		ctl.value = in_ready ? value : value_q;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [31:0] left_w;
		logic        up_m;
		logic [31:0] up_t;

		if (i == 0) begin : g_head
			assign left_w = ctl.value;
		end else begin : g_body
			assign left_w = entry_w[i-1];
		end

		if (i + GRP < CAPACITY) begin : g_up
			assign up_m = match_w[i+GRP];
			assign up_t = tap_w[i+GRP];
		end else begin : g_end
			assign up_m = 1'b0;
			assign up_t = 32'd0;
		end

		sal_cell #(
			.IDX (i),
			.FW  (FW)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.fill       (fill_q),
			.left_entry (left_w),
			.up_match   (up_m),
			.up_tap     (up_t),
			.entry      (entry_w[i]),
			.match      (match_w[i]),
			.tap        (tap_w[i])
		);
	end

	// lowest match and tail tap among the group now sitting at the head of the chain
	always_comb begin
		grp_hit = 1'b0;
		grp_k   = '0;
		grp_tap = 32'd0;
		for (int k = GRP - 1; k >= 0; k--) begin
			if (match_w[k]) begin
				grp_hit = 1'b1;
				grp_k   = GIW'(k);
			end
			grp_tap = grp_tap | tap_w[k];
		end
		pos = PW'(grp_q) * PW'(GRP) + PW'(grp_k);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sal_pkg::S_IDLE: begin
				if (acc) begin
					state_d = sal_pkg::S_LOAD;
				end
			end
			sal_pkg::S_LOAD: state_d = sal_pkg::S_SCAN;
			sal_pkg::S_SCAN: begin
				if (grp_q == GW'(NGRP - 1)) begin
					state_d = sal_pkg::S_DONE;
				end
			end
			sal_pkg::S_DONE: begin
				if (out_load) begin
					state_d = sal_pkg::S_IDLE;
				end
			end
			default: state_d = sal_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sal_pkg::S_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.shift || ctl.app) begin
				fill_q <= fill_q + FW'(1);
			end else if (acc && (action == sal_pkg::ACT_REMOVE) && fill_q != '0) begin
				fill_q <= fill_q - FW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			act_q   <= sal_pkg::act_t'(action);
			value_q <= value;
			found_q <= 1'b0;
			idx_q   <= 4'd0;
			case (sal_pkg::act_t'(action)) inside
				sal_pkg::ACT_APPEND, sal_pkg::ACT_INSERT:
					status_q <= full ? sal_pkg::ST_FULL : sal_pkg::ST_OK;
				sal_pkg::ACT_REMOVE:
					status_q <= (fill_q == '0) ? sal_pkg::ST_EMPTY : sal_pkg::ST_OK;
				default:
					status_q <= sal_pkg::ST_MISS;
			endcase
		end
		if (ctl.load) begin
			grp_q  <= '0;
			last_q <= 32'd0;
		end
		if (ctl.scan) begin
			grp_q  <= grp_q + GW'(1);
			last_q <= last_q | grp_tap;
			// only a search reports a hit
			if (grp_hit && !found_q && act_q == sal_pkg::ACT_SEARCH) begin
				found_q <= 1'b1;
				idx_q   <= 4'(pos);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (act_q == sal_pkg::ACT_SEARCH) begin
				out_status_q <= found_q ? sal_pkg::ST_OK : sal_pkg::ST_MISS;
			end else begin
				out_status_q <= status_q;
			end
			out_found_q <= found_q;
			out_idx_q   <= idx_q;
			out_first_q <= (fill_q == '0) ? 32'hFFFF_FFFF : entry_w[0];
			out_last_q  <= (fill_q == '0) ? 32'hFFFF_FFFF : last_q;
			out_count_q <= 5'(fill_q);
			out_empty_q <= fill_q == '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign found       = out_found_q;
	assign found_index = out_idx_q;
	assign first_value = out_first_q;
	assign last_value  = out_last_q;
	assign count       = out_count_q;
	assign is_empty    = out_empty_q;

`ifndef SYNTH
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && full && (action == sal_pkg::ACT_APPEND || action == sal_pkg::ACT_INSERT))
		|=> $stable(fill_q))
		else $error("full list changed on rejected add");

	a_remove_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && action == sal_pkg::ACT_REMOVE && fill_q != '0)
		|=> fill_q == $past(fill_q) - FW'(1))
		else $error("remove did not drop the count by one");

	a_scan_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sal_pkg::S_SCAN) |=> $stable(fill_q))
		else $error("count moved during scan");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == sal_pkg::S_DONE)
		else $error("result raised outside the result state");
`endif

endmodule

[tb/sal_monitor.sv]
// Result checker for the shift array list: tracks accepted items, predicts and compares results.
`timescale 1ns / 1ps
module sal_monitor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         action,
	input  logic signed [31:0] value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         status,
	input  logic               found,
	input  logic [3:0]         found_index,
	input  logic signed [31:0] first_value,
	input  logic signed [31:0] last_value,
	input  logic [4:0]         count,
	input  logic               is_empty,
	output int                 mismatches,
	output int                 awaited,
	output int                 results_seen,
	output int                 full_rejects,
	output int                 empty_rejects,
	output int                 search_hits
);

	localparam int DEPTH = 16;

	typedef struct packed {
		sal_pkg::status_t   st;
		logic               hit;
		logic [3:0]         idx;
		logic signed [31:0] head;
		logic signed [31:0] tail;
		logic [4:0]         cnt;
		logic               empty;
	} list_view_t;

	list_view_t         awaited_views[$];
	logic signed [31:0] held[DEPTH];
	int unsigned        held_n;
	int                 n_bad, n_seen, n_full, n_empty, n_hit;
	list_view_t         want, got;

	// Applies one action to the mirrored list and returns the view the block should report.
	function automatic list_view_t apply_list_op(input sal_pkg::act_t op,
		input logic signed [31:0] v);
		list_view_t r;
		r.st  = sal_pkg::ST_OK;
		r.hit = 1'b0;
		r.idx = 4'd0;
		case (op)
		sal_pkg::ACT_APPEND: begin
			if (held_n >= DEPTH) begin
				r.st = sal_pkg::ST_FULL;
			end else begin
				held[held_n] = v;
				held_n++;
			end
		end
		sal_pkg::ACT_INSERT: begin
			if (held_n >= DEPTH) begin
				r.st = sal_pkg::ST_FULL;
			end else begin
				for (int i = held_n; i > 0; i--)
					held[i] = held[i - 1];
				held[0] = v;
				held_n++;
			end
		end
		sal_pkg::ACT_REMOVE: begin
			if (held_n == 0)
				r.st = sal_pkg::ST_EMPTY;
			else
				held_n--;
		end
		default: begin
			r.st = sal_pkg::ST_MISS;
			// lowest matching position wins
			for (int i = 0; i < held_n; i++) begin
				if (!r.hit && held[i] == v) begin
					r.st  = sal_pkg::ST_OK;
					r.hit = 1'b1;
					r.idx = 4'(i);
				end
			end
		end
		endcase
		r.head  = (held_n != 0) ? held[0] : -32'sd1;
		r.tail  = (held_n != 0) ? held[held_n - 1] : -32'sd1;
		r.cnt   = 5'(held_n);
		r.empty = (held_n == 0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited_views.delete();
			held_n  = 0;
			n_bad   = 0;
			n_seen  = 0;
			n_full  = 0;
			n_empty = 0;
			n_hit   = 0;
		end else begin
			// results leave before items of the same edge could produce one
			if (out_valid && out_ready) begin
				n_seen++;
				got = '{sal_pkg::status_t'(status), found, found_index, first_value,
					last_value, count, is_empty};
				if (awaited_views.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("%0t: result with no transaction waiting: st=%0d cnt=%0d",
							$realtime, status, count);
				end else begin
					want = awaited_views.pop_front();
					if (got.st !== want.st || got.hit !== want.hit || got.idx !== want.idx ||
						got.head !== want.head || got.tail !== want.tail ||
						got.cnt !== want.cnt || got.empty !== want.empty) begin
						n_bad++;
						if (n_bad <= 10) begin
							$display("%0t: result %0d: expected st=%0d hit=%0d idx=%0d first=%0d last=%0d cnt=%0d empty=%0d",
								$realtime, n_seen, want.st, want.hit, want.idx, want.head,
								want.tail, want.cnt, want.empty);
							$display("%0t: result %0d: got      st=%0d hit=%0d idx=%0d first=%0d last=%0d cnt=%0d empty=%0d",
								$realtime, n_seen, got.st, got.hit, got.idx, got.head,
								got.tail, got.cnt, got.empty);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				want = apply_list_op(sal_pkg::act_t'(action), value);
				awaited_views.push_back(want);
				if (want.st == sal_pkg::ST_FULL)
					n_full++;
				if (want.st == sal_pkg::ST_EMPTY)
					n_empty++;
				if (want.hit)
					n_hit++;
			end
		end
		mismatches    <= n_bad;
		awaited       <= awaited_views.size();
		results_seen  <= n_seen;
		full_rejects  <= n_full;
		empty_rejects <= n_empty;
		search_hits   <= n_hit;
	end

endmodule

[tb/testbench.sv]
// Top of the shift array list testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;

	localparam int ITEMS = 2000;
	localparam int BATCH = 50;
	localparam int LIMIT = 600000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         action = sal_pkg::ACT_APPEND;
	logic signed [31:0] value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic               found;
	logic [3:0]         found_index;
	logic signed [31:0] first_value;
	logic signed [31:0] last_value;
	logic [4:0]         count;
	logic               is_empty;

	int mismatches, awaited, results_seen, full_rejects, empty_rejects, search_hits;
	int cycles = 0;
	int sent = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit hold_seen = 1'b0;
	int stall_left = 0;
	int rr;
	int bias;

	// recently stored values, so that searches find something
	logic signed [31:0] recent[16];
	int recent_n = 0;
	int recent_wr = 0;

	shift_array_list u_top (.*);

	sal_monitor u_mon (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, awaited);
			$display("shift_array_list: mismatch");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			stall_left = 300;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (calm) begin
			out_ready <= 1'b1;
		end else begin
			rr = $urandom_range(0, 99);
			if (rr < 75) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				stall_left = (rr < 97) ? $urandom_range(0, 3) : $urandom_range(10, 60);
			end
		end
	end

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// bias 0 grows the list, 1 drains it, 2 is even
	function automatic sal_pkg::act_t pick_action(input int b);
		int r;
		r = $urandom_range(0, 99);
		case (b)
		0: return (r < 35) ? sal_pkg::ACT_APPEND : (r < 70) ? sal_pkg::ACT_INSERT
			: (r < 80) ? sal_pkg::ACT_REMOVE : sal_pkg::ACT_SEARCH;
		1: return (r < 10) ? sal_pkg::ACT_APPEND : (r < 20) ? sal_pkg::ACT_INSERT
			: (r < 75) ? sal_pkg::ACT_REMOVE : sal_pkg::ACT_SEARCH;
		default: return sal_pkg::act_t'(r % 4);
		endcase
	endfunction

	function automatic logic signed [31:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return $urandom;
		if (r < 55)
			return $urandom_range(0, 8) - 4;
		if (r < 65) begin
			case ($urandom_range(0, 3))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return -32'sd1;
			default: return 32'sd0;
			endcase
		end
		if (recent_n > 0)
			return recent[$urandom_range(0, recent_n - 1)];
		return $urandom;
	endfunction

	// Offers one transaction after a gap and returns at the edge where it is taken.
	task automatic drive_item(input sal_pkg::act_t op, input logic signed [31:0] v,
		input int gap);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action   <= op;
		value    <= v;
		do
			@(posedge clk);
		while (!in_ready);
		sent++;
		if (op == sal_pkg::ACT_APPEND || op == sal_pkg::ACT_INSERT) begin
			recent[recent_wr] = v;
			recent_wr = (recent_wr + 1) % 16;
			if (recent_n < 16)
				recent_n++;
		end
	endtask

	task automatic go_idle();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// empty list: remove is rejected and search misses
		drive_item(sal_pkg::ACT_REMOVE, 32'sd7, 0);
		drive_item(sal_pkg::ACT_SEARCH, 32'sd0, 0);
		drive_item(sal_pkg::ACT_APPEND, 32'sh7FFF_FFFF, 0);
		drive_item(sal_pkg::ACT_INSERT, 32'sh8000_0000, rand_gap());
		drive_item(sal_pkg::ACT_APPEND, -32'sd1, 0);
		drive_item(sal_pkg::ACT_SEARCH, 32'sh8000_0000, 0);
		drive_item(sal_pkg::ACT_SEARCH, -32'sd1, rand_gap());
		drive_item(sal_pkg::ACT_SEARCH, 32'sd12345, 0);
		drive_item(sal_pkg::ACT_REMOVE, 32'sd0, 0);
		// fill to capacity with repeats, then push against the full list
		for (int i = 0; i < 14; i++)
			drive_item((i % 2) ? sal_pkg::ACT_INSERT : sal_pkg::ACT_APPEND, i % 5,
				rand_gap());
		drive_item(sal_pkg::ACT_APPEND, 32'sd99, 0);
		drive_item(sal_pkg::ACT_INSERT, 32'sd98, 0);
		drive_item(sal_pkg::ACT_SEARCH, 32'sd4, 0);

		for (int b = 0; b < ITEMS / BATCH; b++) begin
			calm = ($urandom_range(0, 3) == 0);
			bias = $urandom_range(0, 2);
			if (b == 10) begin
				go_idle();
				while (awaited != 0)
					@(posedge clk);
			end
			if (b == 20) begin
				// back-to-back items against a stalled receiver
				calm = 1'b1;
				hold_req = ~hold_req;
			end
			for (int k = 0; k < BATCH; k++)
				drive_item(pick_action(bias), pick_value(), rand_gap());
		end
		go_idle();

		while (awaited != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d transactions in and %0d results out in %0d cycles",
			sent, results_seen, cycles);
		$display("with %0d full rejections, %0d empty rejections and %0d search hits",
			full_rejects, empty_rejects, search_hits);
		if (mismatches == 0 && awaited == 0)
			$display("shift_array_list: match");
		else
			$display("shift_array_list: mismatch");
		$finish;
	end

endmodule
